/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the ground distance unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk and ignored while rst is high.
`define ODG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and ignored while rst is high.
`define ODG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/odg_pkg.sv */
// Package with the constants and types of the ground distance unit.
`timescale 1ns / 1ps

package odg_pkg;

  // Register indexes of the configuration port.
  localparam logic REG_HEIGHT = 1'b0;
  localparam logic REG_RADIUS = 1'b1;

  localparam logic [11:0] HEIGHT_RESET = 12'd650;
  localparam logic [9:0]  RADIUS_RESET = 10'd240;

  // Height gain (1 - k^2) * 1e8 and its product with the reset height.
  localparam logic [36:0] HEIGHT_GAIN = 37'd23926716;
  localparam logic [36:0] HG_RESET    = 37'd15552365400;

  // 2 * 0.9784 * 0.0099 * 1e8, the lens split 180 and the base 60 * 1e8.
  localparam logic [30:0] RADIUS_GAIN = 31'd1937232;
  localparam logic [38:0] SPLIT_LEN   = 39'd180;
  localparam logic [32:0] DEN_BASE    = 33'd6000000000;
  localparam int          DIV_STEPS   = 55;

  // 10 * (1 + k^2) * 1e8 and 10 * 2k * 1e8.
  localparam logic [52:0] FOCAL_GAIN = 53'd1760732840;
  localparam logic [52:0] ROOT_GAIN  = 53'd1744400000;

  // Pixel to Q4.16 millimetre scale: pix * 811008 / 1250, via reciprocal.
  localparam logic [29:0] PIX_SCALE = 30'd811008;
  localparam logic [29:0] PIX_DIV   = 30'd1250;
  localparam int          RECIP_SH  = 40;
  localparam logic [63:0] PIX_RECIP = (64'd1 << RECIP_SH) / 64'd1250;
  localparam logic [63:0] PIX_K     = 64'd811008 * PIX_RECIP;

  localparam logic [9:0]  SAT_VALUE = 10'd999;
  localparam logic [63:0] SAT_MUL   = 64'd999;

  localparam int SQRT_CELLS = 22;
  localparam int DIV_CELLS  = 10;

  // Coefficients that follow from the configuration registers.
  typedef struct packed {
    logic        busy;
    logic        fzero;
    logic [36:0] hg;
    logic [43:0] ff;
    logic [52:0] a10;
  } coef_t;

  // Flags that travel beside the quotient.
  typedef struct packed {
    logic sat;
    logic zero;
  } div_tag_t;

endpackage

/* sv/omni_mirror_ground_distance_unit.sv */
// Top level of the omnidirectional mirror ground distance unit.
`timescale 1ns / 1ps
// Converts a radial pixel distance in an omnidirectional image into a ground
// distance in centimeters, using a hyperbolic mirror model.
// Input channel s_*: one item per pixel distance, s_tdata[9:0] holds it.
// Output channel m_*: m_tdata[9:0] is the ground distance (0..999) and
// m_tuser is set when the result was clamped to 999 (ray above the horizon,
// zero focal length, or a distance beyond 999 cm).
// Configuration: cfg_we writes cfg_data into register cfg_index at a clock
// edge; index 0 is camera height (mm), index 1 the outer mirror radius (px).
// Throughput is one item per clock unless the output stalls or setup runs.
// Stages A to C do the pixel scaling and squaring, 22 cells the square root
// chain (one root bit per cell), stages D to F the products and range checks,
// 10 cells the divider chain (one quotient bit per cell), then the output register.
// After reset, and after every write of the outer radius, a serial divider
// derives the focal length; s_tready stays low during that time.
// When the receiver stalls, each stage holds its item and empty stages keep
// filling, so the input is still taken until the pipeline is full.
module omni_mirror_ground_distance_unit import odg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] pixel_distance
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [9:0] ground_distance
  output logic        m_tuser,   // [0] saturated
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

`include "assert_macros.svh"

  coef_t coef;

  odg_coef u_coef (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .coef     (coef)
  );

  // Ready of each stage: a stage may load when it is empty or drains.
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_o;
  logic va, vb, vc, vd, ve, vf;

  // Stage A: reciprocal estimate of pix * 811008 / 1250.
  logic [9:0]  pix_a;
  logic [19:0] q0_a;
  logic [63:0] xprod;

  // Stage B: corrected pixel position x in Q4.16 millimeters.
  logic [19:0] x_b;
  logic [29:0] scaled;
  logic [29:0] resid;

  // Stage C: radicand x^2 + f^2.
  logic [43:0] rad_c;
  logic [19:0] x_c;

  // Square root chain.
  logic        sq_v    [SQRT_CELLS+1];
  logic [43:0] sq_rad  [SQRT_CELLS+1];
  logic [25:0] sq_rem  [SQRT_CELLS+1];
  logic [21:0] sq_root [SQRT_CELLS+1];
  logic [19:0] sq_x    [SQRT_CELLS+1];
  logic        sq_rdy  [SQRT_CELLS+1];

  // Stages D, E, F: numerator, denominator, range checks.
  logic [56:0] num_d;
  logic [54:0] den_d;
  logic        fz_d;
  logic [56:0] num_e;
  logic [53:0] den_e;
  logic [63:0] lim_e;
  logic        sat_e, zero_e;
  logic [63:0] rem_f;
  logic [63:0] dsh_f;
  div_tag_t    tag_f;

  // Divider chain.
  logic        dv_v   [DIV_CELLS+1];
  logic [63:0] dv_rem [DIV_CELLS+1];
  logic [63:0] dv_dsh [DIV_CELLS+1];
  logic [9:0]  dv_quo [DIV_CELLS+1];
  div_tag_t    dv_tag [DIV_CELLS+1];
  logic        dv_rdy [DIV_CELLS+1];

  assign rdy_o    = !m_tvalid || m_tready;
  assign rdy_f    = !vf || dv_rdy[0];
  assign rdy_e    = !ve || rdy_f;
  assign rdy_d    = !vd || rdy_e;
  assign rdy_c    = !vc || sq_rdy[0];
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign s_tready = rdy_a && !coef.busy;

  assign xprod  = {54'd0, s_tdata[9:0]} * PIX_K;
  assign scaled = {20'd0, pix_a} * PIX_SCALE;
  assign resid  = scaled - 30'({10'd0, q0_a} * PIX_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (rdy_a) va <= s_tvalid && !coef.busy;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
    end
    if (rdy_a) begin
      pix_a <= s_tdata[9:0];
      q0_a  <= xprod[RECIP_SH+19:RECIP_SH];
    end
    if (rdy_b) begin
      x_b <= (resid >= PIX_DIV) ? q0_a + 20'd1 : q0_a;
    end
    if (rdy_c) begin
      rad_c <= ({24'd0, x_b} * {24'd0, x_b}) + coef.ff;
      x_c   <= x_b;
    end
  end

  assign sq_v[0]    = vc;
  assign sq_rad[0]  = rad_c;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_x[0]    = x_c;
  assign sq_rdy[SQRT_CELLS] = rdy_d;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    odg_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sq_v[i]),
      .in_rad   (sq_rad[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_x     (sq_x[i]),
      .ready_in (sq_rdy[i+1]),
      .out_valid(sq_v[i+1]),
      .out_rad  (sq_rad[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_x    (sq_x[i+1]),
      .ready_out(sq_rdy[i])
    );
  end

  // The denominator is signed; its true value always fits in 55 bits, so
  // modular arithmetic gives the right two's complement form.
  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
    end else begin
      if (rdy_d) vd <= sq_v[SQRT_CELLS];
      if (rdy_e) ve <= vd;
      if (rdy_f) vf <= ve;
    end
    if (rdy_d) begin
      num_d <= {20'd0, coef.hg} * {37'd0, sq_x[SQRT_CELLS]};
      den_d <= {2'b00, coef.a10} - 55'({31'd0, sq_root[SQRT_CELLS]} * ROOT_GAIN);
      fz_d  <= coef.fzero;
    end
    if (rdy_e) begin
      // Zero focal length or a ray at the horizon saturate; a ray above the
      // horizon saturates unless the camera height or pixel gives zero.
      sat_e  <= fz_d || (den_d == '0) || (den_d[54] && (num_d != '0));
      zero_e <= !fz_d && den_d[54] && (num_d == '0);
      num_e  <= num_d;
      den_e  <= den_d[53:0];
      lim_e  <= {10'd0, den_d[53:0]} * SAT_MUL;
    end
    if (rdy_f) begin
      // Beyond 999 cm exactly when num exceeds 999 * den.
      tag_f.sat  <= sat_e || (!zero_e && ({7'd0, num_e} > lim_e));
      tag_f.zero <= zero_e;
      rem_f      <= {7'd0, num_e};
      dsh_f      <= {1'b0, den_e, 9'd0};
    end
  end

  assign dv_v[0]   = vf;
  assign dv_rem[0] = rem_f;
  assign dv_dsh[0] = dsh_f;
  assign dv_quo[0] = '0;
  assign dv_tag[0] = tag_f;
  assign dv_rdy[DIV_CELLS] = rdy_o;

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    odg_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (dv_v[j]),
      .in_rem   (dv_rem[j]),
      .in_dsh   (dv_dsh[j]),
      .in_quo   (dv_quo[j]),
      .in_tag   (dv_tag[j]),
      .ready_in (dv_rdy[j+1]),
      .out_valid(dv_v[j+1]),
      .out_rem  (dv_rem[j+1]),
      .out_dsh  (dv_dsh[j+1]),
      .out_quo  (dv_quo[j+1]),
      .out_tag  (dv_tag[j+1]),
      .ready_out(dv_rdy[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy_o) begin
      m_tvalid <= dv_v[DIV_CELLS];
    end
    if (rdy_o) begin
      m_tuser <= dv_tag[DIV_CELLS].sat;
      if (dv_tag[DIV_CELLS].sat) begin
        m_tdata <= {6'd0, SAT_VALUE};
      end else if (dv_tag[DIV_CELLS].zero) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {6'd0, dv_quo[DIV_CELLS]};
      end
    end
  end

  `ODG_ASSERT_NOW(a_busy_blocks_input, coef.busy, !s_tready, "input taken during coefficient setup")
  `ODG_ASSERT_NOW(a_sat_value, m_tvalid && m_tuser, m_tdata[9:0] == SAT_VALUE, "saturated item not 999")
  `ODG_ASSERT_NOW(a_range, m_tvalid, m_tdata[9:0] <= SAT_VALUE, "ground distance above 999")
  `ODG_ASSERT_NEXT(a_radius_restarts, cfg_we && cfg_index == REG_RADIUS, coef.busy, "radius write did not start setup")

endmodule

/* sv/odg_sqrt_cell.sv */
// One cell of the square root chain: one result bit per cell.
`timescale 1ns / 1ps

module odg_sqrt_cell import odg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [43:0] in_rad,
  input  logic [25:0] in_rem,
  input  logic [21:0] in_root,
  input  logic [19:0] in_x,
  input  logic        ready_in,
  output logic        out_valid,
  output logic [43:0] out_rad,
  output logic [25:0] out_rem,
  output logic [21:0] out_root,
  output logic [19:0] out_x,
  output logic        ready_out
);

  logic [25:0] rem_sh;
  logic [25:0] trial;
  logic        ge;

  assign ready_out = !out_valid || ready_in;
  assign rem_sh    = {in_rem[23:0], in_rad[43:42]};
  assign trial     = {2'b00, in_root, 2'b01};
  assign ge        = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_out) begin
      out_valid <= in_valid;
    end
    if (ready_out) begin
      out_rad  <= {in_rad[41:0], 2'b00};
      out_rem  <= ge ? rem_sh - trial : rem_sh;
      out_root <= {in_root[20:0], ge};
      out_x    <= in_x;
    end
  end

endmodule

/* sv/odg_div_cell.sv */
// One cell of the restoring divider chain: one quotient bit per cell.
`timescale 1ns / 1ps

module odg_div_cell import odg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] in_rem,
  input  logic [63:0] in_dsh,
  input  logic [9:0]  in_quo,
  input  div_tag_t    in_tag,
  input  logic        ready_in,
  output logic        out_valid,
  output logic [63:0] out_rem,
  output logic [63:0] out_dsh,
  output logic [9:0]  out_quo,
  output div_tag_t    out_tag,
  output logic        ready_out
);

  logic ge;

  assign ready_out = !out_valid || ready_in;
  assign ge        = in_rem >= in_dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_out) begin
      out_valid <= in_valid;
    end
    if (ready_out) begin
      out_rem <= ge ? in_rem - in_dsh : in_rem;
      out_dsh <= in_dsh >> 1;
      out_quo <= {in_quo[8:0], ge};
      out_tag <= in_tag;
    end
  end

endmodule

/* sv/odg_coef.sv */
// Configuration registers and the serial unit that derives the focal coefficients.
`timescale 1ns / 1ps

module odg_coef import odg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  output coef_t       coef
);

  typedef enum logic [2:0] {ST_GAIN, ST_LOAD, ST_DIV, ST_PROD, ST_IDLE} state_t;

  state_t      state;
  logic [9:0]  radius;
  logic [30:0] gain;
  logic [54:0] num_sh;
  logic [32:0] dvs;
  logic [32:0] rem;
  logic [21:0] quo;
  logic [5:0]  cnt;
  logic [33:0] trial;
  logic        ge;
  logic        fzero;
  logic [36:0] hg;
  logic [43:0] ff;
  logic [52:0] a10;

  assign trial = {rem, num_sh[54]};
  assign ge    = trial >= {1'b0, dvs};
  assign coef  = '{busy: (state != ST_IDLE), fzero: fzero, hg: hg, ff: ff, a10: a10};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_GAIN;
      radius <= RADIUS_RESET;
      hg     <= HG_RESET;
    end else begin
      if (cfg_we && cfg_index == REG_HEIGHT) begin
        hg <= {25'd0, cfg_data} * HEIGHT_GAIN;
      end
      case (state)
        ST_GAIN: begin
          gain  <= {21'd0, radius} * RADIUS_GAIN;
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          num_sh <= {({8'd0, gain} * SPLIT_LEN), 16'd0};
          dvs    <= DEN_BASE + {2'b00, gain};
          rem    <= '0;
          quo    <= '0;
          cnt    <= '0;
          state  <= ST_DIV;
        end
        ST_DIV: begin
          rem    <= ge ? 33'(trial - {1'b0, dvs}) : trial[32:0];
          quo    <= {quo[20:0], ge};
          num_sh <= {num_sh[53:0], 1'b0};
          cnt    <= cnt + 6'd1;
          if (cnt == 6'(DIV_STEPS - 1)) begin
            state <= ST_PROD;
          end
        end
        ST_PROD: begin
          ff    <= {22'd0, quo} * {22'd0, quo};
          a10   <= {31'd0, quo} * FOCAL_GAIN;
          fzero <= (quo == '0);
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cfg_we && cfg_index == REG_RADIUS) begin
        radius <= cfg_data[9:0];
        state  <= ST_GAIN;
      end
    end
  end

endmodule

/* verif/odg_checker.sv */
// Checker of the ground distance unit: predicts each result and compares it.
`timescale 1ns / 1ps

module odg_checker import odg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        m_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          result_count,
  output int          sat_count
);

  typedef struct packed {
    logic [9:0] distance;
    logic       sat;
  } ground_t;

  logic [11:0] height;
  logic [9:0]  radius;
  ground_t     ground_q[$];

  // Bitwise integer square root of a 64-bit value.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Ground distance in cm for one pixel distance, clamped to 999.
  function automatic ground_t ground_of(logic [9:0] pix, logic [11:0] hgt, logic [9:0] rad);
    longint unsigned gain, xu, fu;
    longint x_q, f_q, h_q, num, den, quo, rem;
    ground_t g;
    gain = 64'(rad) * 64'd1937232;
    xu = ((64'(pix) * 64'd99) << 16) / 64'd10000;
    fu = ((64'd180 * gain) << 16) / (64'd6000000000 + gain);
    x_q = longint'(xu);
    f_q = longint'(fu);
    h_q = longint'(int_sqrt(xu * xu + fu * fu));
    num = longint'(hgt) * 64'sd23926716 * x_q;
    den = 64'sd10 * (64'sd176073284 * f_q - 64'sd174440000 * h_q);
    g.sat = 1'b0;
    g.distance = '0;
    if (f_q == 0 || den == 0) begin
      g.sat = 1'b1;
    end else if (den < 0) begin
      if (num > 0) g.sat = 1'b1;
    end else begin
      quo = num / den;
      rem = num % den;
      if (quo > 999 || (quo == 999 && rem != 0)) g.sat = 1'b1;
      else g.distance = quo[9:0];
    end
    if (g.sat) g.distance = SAT_VALUE;
    return g;
  endfunction

  task automatic report(string what, logic [9:0] got, logic [9:0] want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  assign pending = ground_q.size();

  always @(posedge clk) begin
    ground_t want;
    if (rst) begin
      height <= HEIGHT_RESET;
      radius <= RADIUS_RESET;
      ground_q.delete();
      fail_count <= 0;
      result_count <= 0;
      sat_count <= 0;
    end else begin
      if (s_tvalid && s_tready) ground_q = {ground_q, ground_of(s_tdata[9:0], height, radius)};
      if (m_tvalid && m_tready) begin
        result_count <= result_count + 1;
        if (m_tuser) sat_count <= sat_count + 1;
        if (ground_q.size() == 0) begin
          report("unexpected item, distance", m_tdata[9:0], 10'd0);
        end else begin
          want = ground_q.pop_front();
          if (m_tdata[9:0] != want.distance) begin
            report("ground distance", m_tdata[9:0], want.distance);
          end
          if (m_tuser != want.sat) report("saturated flag", 10'(m_tuser), 10'(want.sat));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_HEIGHT) height <= cfg_data;
        else radius <= cfg_data[9:0];
      end
    end
  end

endmodule

/* verif/tb_top.sv */
// Testbench top of the ground distance unit: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top import odg_pkg::*;;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_HEIGHT;
  logic [11:0] cfg_data = '0;

  int fail_count, pending, result_count, sat_count;
  int idle_cycles = 0;
  int items_sent = 0;
  bit long_hold = 1'b0;   // Receiver holds off once, long enough for the pipeline to fill.
  bit ready_random = 1'b1;

  always #10 clk = ~clk;

  omni_mirror_ground_distance_unit u_top (.*);

  odg_checker u_chk (.*);

  // Watchdog: counts cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d quiet cycles.", IDLE_LIMIT);
      $display("omni_mirror_ground_distance_unit: mismatch");
      $finish;
    end
  end

  // Receiver: random stalls before each item, with stretches of none, and one
  // long hold-off counted here while the sender keeps offering.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = ready_random ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Sends one pixel distance after an optional random gap; valid stays up until taken.
  task automatic send_pixel(logic [9:0] pix, bit with_gap);
    int gap;
    gap = with_gap ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, pix};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Waits until every result has come, then lets the pipeline drain.
  task automatic wait_empty();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes one register, meant while the block is idle; the task does not wait for it.
  task automatic write_reg(logic idx, logic [11:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [11:0] heights[6];
    logic [9:0]  radii[6];
    logic [9:0]  edge_pix[10];
    int phase;
    heights = '{12'd650, 12'd0, 12'd4095, 12'd1, 12'd1200, 12'd2730};
    radii   = '{10'd240, 10'd0, 10'd1023, 10'd1, 10'd512, 10'd85};
    edge_pix = '{10'd0, 10'd1, 10'd2, 10'd511, 10'd512, 10'd1023, 10'd1022,
                 10'd341, 10'd682, 10'd120};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings: field extremes, single bits, horizon.
    foreach (edge_pix[i]) send_pixel(edge_pix[i], 1'b0);
    for (int b = 0; b < 10; b++) send_pixel(10'(1 << b), 1'b1);
    wait_empty();
    // Zero height and zero radius special cases.
    write_reg(REG_HEIGHT, 12'd0);
    send_pixel(10'd100, 1'b0);
    send_pixel(10'd1023, 1'b0);
    wait_empty();
    write_reg(REG_RADIUS, 12'd0);
    write_reg(REG_HEIGHT, 12'd4095);
    send_pixel(10'd0, 1'b0);
    send_pixel(10'd200, 1'b0);
    wait_empty();

    // Random phases over several settings, extremes among them.
    for (phase = 0; phase < 12; phase++) begin
      if (phase < 6) begin
        write_reg(REG_HEIGHT, heights[phase]);
        write_reg(REG_RADIUS, {2'b00, radii[phase]});
      end else begin
        write_reg(REG_HEIGHT, 12'($urandom_range(0, 4095)));
        write_reg(REG_RADIUS, 12'($urandom_range(0, 1023)));
      end
      ready_random = (phase % 4) != 3;
      if (phase == 2) long_hold = 1'b1;
      for (int n = 0; n < 160; n++) begin
        logic [9:0] pix;
        // Mostly pixels inside the mirror radius, where distances are finite.
        pix = ($urandom_range(0, 3) != 0 && radii[phase % 6] != 0)
              ? 10'($urandom_range(0, radii[phase % 6])) : 10'($urandom);
        send_pixel(pix, phase == 2 ? 1'b0 : ($urandom_range(0, 2) != 0));
      end
      wait_empty();
    end

    $display("Sent %0d pixel distances over 15 register settings.", items_sent);
    $display("Checked %0d results, %0d of them saturated.", result_count, sat_count);
    if (fail_count == 0) $display("omni_mirror_ground_distance_unit: match");
    else $display("omni_mirror_ground_distance_unit: mismatch");
    $finish;
  end

endmodule
